>>> sv/qhd_pkg.sv
package qhd_pkg;

  localparam int unsigned HDR_MODULE = 10;

  localparam int unsigned PID_FRAME_LEN     = 0;
  localparam int unsigned PID_CONS_SIZE     = 1;
  localparam int unsigned PID_SYM_PER_FRAME = 2;

  localparam logic [31:0] CONS_QAM16 = 32'd16;
  localparam logic [31:0] CONS_QPSK  = 32'd4;

  localparam logic [1:0] GRAY_NEG_OUTER = 2'd0;
  localparam logic [1:0] GRAY_NEG_INNER = 2'd1;
  localparam logic [1:0] GRAY_POS_OUTER = 2'd2;
  localparam logic [1:0] GRAY_POS_INNER = 2'd3;

  localparam int unsigned SYM_BITS = 4;

  typedef struct packed {
    logic data_phase;
    logic drop;
    logic cons16;
    logic cons4;
  } ctrl_t;

endpackage

>>> sv/qhd_slicer.sv
module qhd_slicer #(
  parameter int SAMPLE_BITS     = 16,
  parameter int SAMPLE_INT_BITS = 4
) (
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [1:0]             gray16_o,
  output logic                   pos_o
);

  localparam int THR_SHIFT = (SAMPLE_INT_BITS > SAMPLE_BITS) ? 0 :
                             (SAMPLE_BITS - SAMPLE_INT_BITS);
  localparam logic [SAMPLE_BITS+1:0] OUTER_THR =
    (SAMPLE_INT_BITS > SAMPLE_BITS) ? (SAMPLE_BITS+2)'(1) :
                                      ((SAMPLE_BITS+2)'(2) << THR_SHIFT);
  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   outer;

  assign neg   = sample_i[SAMPLE_BITS-1];
  assign mag   = neg ? (~sample_i + {{(SAMPLE_BITS-1){1'b0}}, 1'b1}) : sample_i;
  assign outer = !(neg && (sample_i == MOST_NEG)) && ({2'b00, mag} >= OUTER_THR);
  assign pos_o = !neg;

  always_comb begin
    case ({neg, outer})
      2'b11:   gray16_o = qhd_pkg::GRAY_NEG_OUTER;
      2'b10:   gray16_o = qhd_pkg::GRAY_NEG_INNER;
      2'b01:   gray16_o = qhd_pkg::GRAY_POS_OUTER;
      default: gray16_o = qhd_pkg::GRAY_POS_INNER;
    endcase
  end

endmodule

>>> sv/qhd_frame_ctrl.sv
module qhd_frame_ctrl #(
  parameter int MODULE_ID_BITS   = 8,
  parameter int PARAM_ID_BITS    = 8,
  parameter int PARAM_VALUE_BITS = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [63:0]   word_i,
  output qhd_pkg::ctrl_t ctrl_o
);

  localparam int HDR_SHIFT = PARAM_ID_BITS + PARAM_VALUE_BITS;
  localparam logic [MODULE_ID_BITS-1:0] MODULE_ONES = {MODULE_ID_BITS{1'b1}};
  localparam logic [63:0] VAL_MASK = (64'd1 << PARAM_VALUE_BITS) - 64'd1;

  logic        data_phase_q, data_phase_d;
  logic [31:0] frame_len_q, frame_len_d;
  logic [31:0] spf_q, spf_d;
  logic [31:0] cons_q, cons_d;
  logic [31:0] remaining_q, remaining_d;

  logic [127:0]               word_ext;
  logic [MODULE_ID_BITS-1:0]  mod_field;
  logic [PARAM_ID_BITS-1:0]   param_id;
  logic [31:0]                param_val;
  logic                       is_param;
  logic                       is_end;
  logic [31:0]                frame_total;
  logic [31:0]                rem_dec;

  assign word_ext    = {64'd0, word_i};
  assign mod_field   = word_ext[HDR_SHIFT +: MODULE_ID_BITS];
  assign param_id    = word_i[PARAM_VALUE_BITS +: PARAM_ID_BITS];
  assign param_val   = 32'(word_i & VAL_MASK);
  assign is_param    = (16'(mod_field) == 16'(qhd_pkg::HDR_MODULE));
  assign is_end      = (mod_field == MODULE_ONES);
  assign frame_total = frame_len_q * spf_q;
  assign rem_dec     = remaining_q - 32'd1;

  always_comb begin
    data_phase_d = data_phase_q;
    frame_len_d  = frame_len_q;
    spf_d        = spf_q;
    cons_d       = cons_q;
    remaining_d  = remaining_q;
    if (step_i) begin
      if (data_phase_q) begin
        remaining_d = rem_dec;
        if (rem_dec == 32'd0) begin
          data_phase_d = 1'b0;
        end
      end else if (is_param) begin
        if (16'(param_id) == 16'(qhd_pkg::PID_FRAME_LEN)) begin
          frame_len_d = param_val;
        end else if (16'(param_id) == 16'(qhd_pkg::PID_CONS_SIZE)) begin
          cons_d = param_val;
        end else if (16'(param_id) == 16'(qhd_pkg::PID_SYM_PER_FRAME)) begin
          spf_d = param_val;
        end
      end else if (is_end) begin
        remaining_d  = frame_total;
        data_phase_d = (frame_total != 32'd0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_phase_q <= 1'b0;
      frame_len_q  <= '0;
      spf_q        <= '0;
      cons_q       <= '0;
      remaining_q  <= '0;
    end else begin
      data_phase_q <= data_phase_d;
      frame_len_q  <= frame_len_d;
      spf_q        <= spf_d;
      cons_q       <= cons_d;
      remaining_q  <= remaining_d;
    end
  end

  assign ctrl_o.data_phase = data_phase_q;
  assign ctrl_o.drop       = !data_phase_q && is_param;
  assign ctrl_o.cons16     = (cons_q == qhd_pkg::CONS_QAM16);
  assign ctrl_o.cons4      = (cons_q == qhd_pkg::CONS_QPSK);

endmodule

>>> sv/qam_hard_demapper_core.sv
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: in_word, tlast: in_last
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: out_word, tlast: out_last
//
// one word per cycle sustained while the output is not stalled; output valid follows the
// input accept through the input register and then the result register
// rst_ni clears phase, frame settings and both valid flags
// a stalled output holds the input register; a parameter word needs no output slot
module qam_hard_demapper_core #(
  parameter int SAMPLE_BITS      = 16,
  parameter int SAMPLE_INT_BITS  = 4,
  parameter int MODULE_ID_BITS   = 8,
  parameter int PARAM_ID_BITS    = 8,
  parameter int PARAM_VALUE_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // in_word
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // out_word
  output logic        m_axis_tlast_o
);

  logic        in_valid_q;
  logic [63:0] in_word_q;
  logic        in_last_q;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_word_q;
  logic        out_last_q;

  qhd_pkg::ctrl_t ctrl;

  logic       out_free;
  logic       step;
  logic       emit;
  logic       in_fire;
  logic [1:0] i_gray, q_gray;
  logic       i_pos, q_pos;
  logic [qhd_pkg::SYM_BITS-1:0] sym;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && (ctrl.drop || out_free);
  assign emit            = step && !ctrl.drop;
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  qhd_frame_ctrl #(
    .MODULE_ID_BITS  (MODULE_ID_BITS),
    .PARAM_ID_BITS   (PARAM_ID_BITS),
    .PARAM_VALUE_BITS(PARAM_VALUE_BITS)
  ) u_frame_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .word_i(in_word_q),
    .ctrl_o(ctrl)
  );

  qhd_slicer #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .SAMPLE_INT_BITS(SAMPLE_INT_BITS)
  ) u_slicer_i (
    .sample_i(in_word_q[32 +: SAMPLE_BITS]),
    .gray16_o(i_gray),
    .pos_o   (i_pos)
  );

  qhd_slicer #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .SAMPLE_INT_BITS(SAMPLE_INT_BITS)
  ) u_slicer_q (
    .sample_i(in_word_q[SAMPLE_BITS-1:0]),
    .gray16_o(q_gray),
    .pos_o   (q_pos)
  );

  always_comb begin
    if (ctrl.cons16) begin
      sym = {i_gray, q_gray};
    end else if (ctrl.cons4) begin
      sym = {2'b00, i_pos, q_pos};
    end else begin
      sym = '0;
    end
  end

  assign out_valid_d = emit || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_fire || (in_valid_q && !step);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_word_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (emit) begin
      out_word_q <= ctrl.data_phase ? 64'(sym) : in_word_q;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  a_step_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> in_valid_q)
    else $error("step without a held input word");

  a_held_word_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_word_q))
    else $error("held input word changed");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_axis_tvalid_o)
    else $error("emitted word not presented");

  a_symbol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && ctrl.data_phase |=> m_axis_tdata_o[63:qhd_pkg::SYM_BITS] == '0)
    else $error("symbol index out of range");
`endif

endmodule
